/* hw/rtl/ssfc_pkg.sv */
// Shared types, codes and constants for the seismic sample format converter.
package ssfc_pkg;

    typedef enum logic [1:0] {
        FMT_IBM   = 2'd0,
        FMT_INT32 = 2'd1,
        FMT_INT16 = 2'd2,
        FMT_IEEE  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_ROUND = 2'd2,
        ST_NAN   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_IBM_DEC,
        OP_INT_DEC,
        OP_IEEE_PASS,
        OP_IBM_ENC,
        OP_INT32_ENC,
        OP_INT16_ENC
    } op_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] data_in;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic        last_out;
    } out_item_t;

    // Classified work handed from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic        sign;
        logic [31:0] mag;    // integer magnitude for integer decode
        logic [31:0] word;
        logic        last;
    } work_t;

    localparam logic [1:0]  ADDR_SAMPLE_FORMAT = 2'd0;
    localparam logic [31:0] F_EXP_MASK = 32'h7f800000;
    localparam logic [31:0] F_MAN_MASK = 32'h007fffff;
    localparam int          IBM_BIAS   = 64;

    // Position of the highest set bit (0 when zero).
    function automatic logic [5:0] msb32(input logic [31:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

/* hw/rtl/ssfc_front.sv */
// Front end: accepts input beats, picks the operation and prepares operands.
module ssfc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         fmt,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssfc_pkg::in_item_t in_item,
    output logic               wk_valid,
    input  logic               wk_ready,
    output ssfc_pkg::work_t    wk
);
    import ssfc_pkg::*;

    logic  valid_reg;
    work_t wk_reg;
    work_t wk_next;

    assign in_ready = !valid_reg || wk_ready;
    assign wk_valid = valid_reg;
    assign wk       = wk_reg;

    always_comb
    begin
        wk_next      = '0;
        wk_next.word = in_item.data_in;
        wk_next.last = in_item.last_in;
        wk_next.op   = OP_IEEE_PASS;
        if (!in_item.cmd)
        begin
            case (fmt)
                FMT_IBM:   wk_next.op = OP_IBM_DEC;
                FMT_INT32:
                begin
                    wk_next.op   = OP_INT_DEC;
                    wk_next.sign = in_item.data_in[31];
                    wk_next.mag  = in_item.data_in[31] ? (32'd0 - in_item.data_in)
                                                       : in_item.data_in;
                end
                FMT_INT16:
                begin
                    wk_next.op   = OP_INT_DEC;
                    wk_next.sign = in_item.data_in[15];
                    wk_next.mag  = in_item.data_in[15]
                        ? (32'h10000 - {16'd0, in_item.data_in[15:0]})
                        : {16'd0, in_item.data_in[15:0]};
                end
                default:   wk_next.op = OP_IEEE_PASS;
            endcase
        end
        else
        begin
            case (fmt)
                FMT_IBM:   wk_next.op = OP_IBM_ENC;
                FMT_INT32: wk_next.op = OP_INT32_ENC;
                FMT_INT16: wk_next.op = OP_INT16_ENC;
                default:   wk_next.op = OP_IEEE_PASS;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            wk_reg <= wk_next;
        end
    end

endmodule

/* hw/rtl/ssfc_queue.sv */
// Two-entry queue between the front end and the back end.
module ssfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ssfc_pkg::work_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ssfc_pkg::work_t rd_data
);
    import ssfc_pkg::*;

    work_t      mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/ssfc_back.sv */
// Back end: performs the conversion and holds the result in an output register.
module ssfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wk_valid,
    output logic                wk_ready,
    input  ssfc_pkg::work_t     wk,
    output logic                out_valid,
    input  logic                out_ready,
    output ssfc_pkg::out_item_t out_item
);
    import ssfc_pkg::*;

    logic      valid_reg;
    out_item_t res_reg;
    out_item_t res_next;

    logic        sign;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic        is_nan;
    logic        is_inf;

    // IBM decode
    logic [23:0] ibm_f;
    logic [4:0]  ibm_p;
    logic signed [10:0] ibm_e;
    logic [23:0] ibm_mant;
    logic [5:0]  dsh;
    logic [23:0] dq;
    logic [24:0] drem;
    logic [24:0] dhalf;
    logic [24:0] dq_r;

    // Integer decode
    logic [4:0]  ip;
    logic [4:0]  ish;
    logic [31:0] iq;
    logic [31:0] irem;
    logic [31:0] ihalf;
    logic [24:0] iq_r;
    logic [7:0]  iexp;
    logic [31:0] inorm;

    // IEEE encode common
    logic [23:0] em;
    logic [8:0]  ee;
    logic [4:0]  emsb;
    logic signed [10:0] eb;
    logic signed [10:0] eh;
    logic signed [10:0] esh;
    logic [23:0] ef;
    logic        elost;

    // Integer encode
    logic signed [10:0] k;
    logic [40:0] imag;
    logic        ilost;
    logic [31:0] ires;
    logic [1:0]  ist;
    logic [32:0] lim;

    assign wk_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = res_reg;

    always_comb
    begin
        sign   = wk.word[31];
        fe     = wk.word[30:23];
        fm     = wk.word[22:0];
        is_nan = (fe == 8'hff) && (fm != '0);
        is_inf = (fe == 8'hff) && (fm == '0);

        ibm_f    = wk.word[23:0];
        ibm_p    = 5'(msb32({8'd0, ibm_f}));
        ibm_e    = 11'($signed({6'd0, ibm_p})) - 11'sd24
                 + 11'($signed({1'b0, wk.word[30:24], 2'b00})) - 11'sd256 + 11'sd127;
        ibm_mant = ibm_f << (5'd23 - ibm_p);
        dsh      = 6'(11'sd1 - ibm_e);
        dq       = ibm_mant >> dsh;
        drem     = {1'b0, ibm_mant} & ((25'd1 << dsh) - 25'd1);
        dhalf    = 25'd1 << (dsh - 6'd1);
        dq_r     = {1'b0, dq} + 25'((drem > dhalf) || (drem == dhalf && dq[0]));

        ip    = 5'(msb32(wk.mag));
        ish   = (ip > 5'd23) ? (ip - 5'd23) : 5'd0;
        iq    = wk.mag >> ish;
        irem  = wk.mag & ((32'd1 << ish) - 32'd1);
        ihalf = (ish == 5'd0) ? 32'd0 : (32'd1 << (ish - 5'd1));
        iq_r  = 25'(iq) + 25'((ish != 5'd0) &&
                ((irem > ihalf) || (irem == ihalf && iq[0])));
        iexp  = 8'(ip) + 8'd127 + 8'(iq_r[24]);
        inorm = (ip <= 5'd23) ? (wk.mag << (5'd23 - ip)) : 32'(iq_r);

        em   = (fe == 8'd0) ? {1'b0, fm} : {1'b1, fm};
        ee   = (fe == 8'd0) ? 9'd1 : {1'b0, fe};
        emsb = 5'(msb32({8'd0, em}));
        eb   = 11'($signed({2'b0, ee})) - 11'sd150 + 11'($signed({6'd0, emsb})) + 11'sd1;
        eh   = ((eb + 11'sd163) >>> 2) - 11'sd40;
        esh  = 11'($signed({2'b0, ee})) - 11'sd126 - (eh <<< 2);
        if (esh >= 0)
        begin
            ef    = em << esh[4:0];
            elost = 1'b0;
        end
        else
        begin
            ef    = em >> 5'(-esh);
            elost = (em & ((24'd1 << 5'(-esh)) - 24'd1)) != '0;
        end

        k = 11'($signed({2'b0, ee})) - 11'sd150;
        if (k > 11'sd8)
        begin
            imag  = 41'd1 << 40;
            ilost = 1'b0;
        end
        else if (k >= 0)
        begin
            imag  = 41'(em) << k[3:0];
            ilost = 1'b0;
        end
        else if (k <= -11'sd32)
        begin
            imag  = '0;
            ilost = em != '0;
        end
        else
        begin
            imag  = 41'(em >> 5'(-k));
            ilost = (em & ((24'd1 << 5'(-k)) - 24'd1)) != '0;
        end
        lim  = (wk.op == OP_INT16_ENC) ? 33'h8000 : 33'h80000000;
        ist  = ilost ? ST_ROUND : ST_OK;
        if (is_nan)
        begin
            ires = '0;
            ist  = ST_NAN;
        end
        else if (sign)
        begin
            if (is_inf || imag > 41'(lim))
            begin
                ires = 32'(33'd0 - lim);
                ist  = ST_SAT;
            end
            else
            begin
                ires = 32'd0 - imag[31:0];
            end
        end
        else if (is_inf || imag > 41'(lim - 33'd1))
        begin
            ires = 32'(lim - 33'd1);
            ist  = ST_SAT;
        end
        else
        begin
            ires = imag[31:0];
        end
        if (wk.op == OP_INT16_ENC)
        begin
            ires = {16'd0, ires[15:0]};
        end

        res_next          = '0;
        res_next.last_out = wk.last;
        case (wk.op)
            OP_IBM_DEC:
            begin
                if (ibm_f == '0)
                begin
                    res_next.data_out = {sign, 31'd0};
                end
                else if (ibm_e >= 11'sd255)
                begin
                    res_next.data_out = {sign, 31'h7f800000};
                    res_next.status   = ST_SAT;
                end
                else if (ibm_e >= 11'sd1)
                begin
                    res_next.data_out = {sign, ibm_e[7:0], ibm_mant[22:0]};
                end
                else
                begin
                    res_next.status = ST_ROUND;
                    // A right shift of 25 or more leaves nothing to round up.
                    if (ibm_e <= -11'sd24)
                    begin
                        res_next.data_out = {sign, 31'd0};
                    end
                    else
                    begin
                        res_next.data_out = {sign, 31'(dq_r)};
                    end
                end
            end
            OP_INT_DEC:
            begin
                if (wk.mag == '0)
                begin
                    res_next.data_out = '0;
                end
                else
                begin
                    res_next.data_out = {wk.sign, iexp, inorm[22:0]};
                    res_next.status   = ((ish != 5'd0) && (irem != '0)) ? ST_ROUND : ST_OK;
                end
            end
            OP_IBM_ENC:
            begin
                if (fe == 8'hff)
                begin
                    res_next.data_out = {sign, 31'h7fffffff};
                    res_next.status   = is_nan ? ST_NAN : ST_SAT;
                end
                else if (fe == 8'd0 && fm == '0)
                begin
                    res_next.data_out = {sign, 31'd0};
                end
                else
                begin
                    res_next.data_out = {sign, 7'(eh + 11'sd64), ef};
                    res_next.status   = elost ? ST_ROUND : ST_OK;
                end
            end
            OP_INT32_ENC, OP_INT16_ENC:
            begin
                res_next.data_out = ires;
                res_next.status   = ist;
            end
            default:
            begin
                res_next.data_out = wk.word;
                res_next.status   = is_nan ? ST_NAN : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wk_ready)
        begin
            valid_reg <= wk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wk_ready && wk_valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* hw/rtl/seismic_sample_format_converter.sv */
// An accepted input beat passes the front register, the two-entry queue and the
// back output register in that order. Throughput: one sample per cycle while
// out_ready holds; the front register, the queue and the back register each stall on their own.
// Reset (rst_n, asynchronous, active low) empties all stages and sets the
// sample format to IBM hex float.
// Top level of the seismic sample format converter.
module seismic_sample_format_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssfc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssfc_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ssfc_pkg::*;

    logic [1:0] fmt_reg;
    logic       f_valid;
    logic       f_ready;
    work_t      f_wk;
    logic       q_valid;
    logic       q_ready;
    work_t      q_wk;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SAMPLE_FORMAT) ? {30'd0, fmt_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_IBM;
        end
        else if (psel && penable && pwrite && paddr == ADDR_SAMPLE_FORMAT)
        begin
            fmt_reg <= pwdata[1:0];
        end
    end

    ssfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .fmt      (fmt_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_data),
        .wk_valid (f_valid),
        .wk_ready (f_ready),
        .wk       (f_wk)
    );

    ssfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_wk),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_wk)
    );

    ssfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wk_valid  (q_valid),
        .wk_ready  (q_ready),
        .wk        (q_wk),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

`ifndef ASSERT_OFF
    a_fmt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(psel && penable && pwrite) |=> $stable(fmt_reg))
        else $error("format register changed without a write");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid)
        else $error("front end dropped a pending beat");
`endif

endmodule

/* sim/ssfc_checker.sv */
// Checker for the sample format converter: predicts each result beat and compares it.
module ssfc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  ssfc_pkg::in_item_t   in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  ssfc_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssfc_pkg::*;

    fmt_t      cur_fmt;
    out_item_t converted_q[$];

    function automatic int top_bit(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                p = i;
            end
        end
        return p;
    endfunction

    // Shift right by sh (1..63), rounding to nearest even.
    function automatic logic [63:0] shift_rne(input logic [63:0] v, input int sh,
                                              output logic lost);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> sh;
        rem  = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        lost = (rem != 0);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    function automatic logic [31:0] ibm_decode(input logic [31:0] w, output status_t st);
        logic [31:0] sgn;
        logic [63:0] f;
        logic [63:0] mant;
        logic        lost;
        int          p;
        int          e;
        sgn = w & 32'h80000000;
        f   = {40'd0, w[23:0]};
        st  = ST_OK;
        if (f == 0)
        begin
            return sgn;
        end
        p    = top_bit(f);
        e    = p - 24 + 4 * (int'(w[30:24]) - IBM_BIAS) + 127;
        mant = f << (23 - p);
        if (e >= 255)
        begin
            st = ST_SAT;
            return sgn | F_EXP_MASK;
        end
        if (e >= 1)
        begin
            return sgn | (32'(e) << 23) | (mant[31:0] & F_MAN_MASK);
        end
        // Below the normal range the status flags rounding whether or not bits drop.
        st = ST_ROUND;
        if (1 - e >= 25)
        begin
            return sgn;
        end
        mant = shift_rne(mant, 1 - e, lost);
        return sgn | mant[31:0];
    endfunction

    function automatic logic [31:0] int_decode(input logic [31:0] sgn, input logic [63:0] mag,
                                               output status_t st);
        logic [63:0] q;
        logic        lost;
        int          p;
        st = ST_OK;
        if (mag == 0)
        begin
            return 32'd0;
        end
        p = top_bit(mag);
        if (p <= 23)
        begin
            q = mag << (23 - p);
        end
        else
        begin
            q = shift_rne(mag, p - 23, lost);
            if (lost)
            begin
                st = ST_ROUND;
            end
            if (q == 64'h1000000)
            begin
                q = q >> 1;
                p = p + 1;
            end
        end
        return sgn | (32'(p + 127) << 23) | (q[31:0] & F_MAN_MASK);
    endfunction

    function automatic logic [31:0] ibm_encode(input logic [31:0] w, output status_t st);
        logic [31:0] sgn;
        logic [63:0] m;
        logic [63:0] f;
        int          e;
        int          b;
        int          h;
        int          sh;
        sgn = w & 32'h80000000;
        e   = int'(w[30:23]);
        m   = {41'd0, w[22:0]};
        st  = ST_OK;
        if (e == 255)
        begin
            st = (m != 0) ? ST_NAN : ST_SAT;
            return sgn | 32'h7fffffff;
        end
        if (e == 0)
        begin
            if (m == 0)
            begin
                return sgn;
            end
            e = 1;
        end
        else
        begin
            m = m | 64'h800000;
        end
        b  = e - 150 + top_bit(m) + 1;
        h  = (b + 3 + 160) / 4 - 40;
        sh = e - 126 - 4 * h;
        if (sh >= 0)
        begin
            f = m << sh;
        end
        else
        begin
            if ((m & ((64'd1 << (-sh)) - 64'd1)) != 0)
            begin
                st = ST_ROUND;
            end
            f = m >> (-sh);
        end
        return sgn | (32'(h + IBM_BIAS) << 24) | (f[31:0] & 32'h00ffffff);
    endfunction

    function automatic logic [31:0] int_encode(input logic [31:0] w, input int width,
                                               output status_t st);
        logic [63:0] m;
        logic [63:0] maxpos;
        logic [63:0] mask;
        logic [63:0] mag;
        int          e;
        int          k;
        e      = int'(w[30:23]);
        m      = {41'd0, w[22:0]};
        maxpos = (64'd1 << (width - 1)) - 64'd1;
        mask   = (64'd1 << width) - 64'd1;
        st     = ST_OK;
        if (e == 255 && m != 0)
        begin
            st = ST_NAN;
            return 32'd0;
        end
        if (e == 255)
        begin
            st  = ST_SAT;
            mag = w[31] ? maxpos + 64'd1 : maxpos;
            return mag[31:0] & mask[31:0];
        end
        if (e == 0)
        begin
            e = 1;
        end
        else
        begin
            m = m | 64'h800000;
        end
        k = e - 150;
        if (k > 8)
        begin
            mag = 64'd1 << 40;
        end
        else if (k >= 0)
        begin
            mag = m << k;
        end
        else if (-k >= 32)
        begin
            if (m != 0)
            begin
                st = ST_ROUND;
            end
            mag = 0;
        end
        else
        begin
            if ((m & ((64'd1 << (-k)) - 64'd1)) != 0)
            begin
                st = ST_ROUND;
            end
            mag = m >> (-k);
        end
        if (w[31])
        begin
            if (mag > maxpos + 64'd1)
            begin
                st  = ST_SAT;
                mag = maxpos + 64'd1;
            end
            mag = (64'd0 - mag) & mask;
            return mag[31:0];
        end
        if (mag > maxpos)
        begin
            st  = ST_SAT;
            mag = maxpos;
        end
        mag = mag & mask;
        return mag[31:0];
    endfunction

    function automatic out_item_t convert_sample(input fmt_t fmt, input in_item_t it);
        out_item_t   r;
        status_t     st;
        logic [31:0] w;
        logic [63:0] mag;
        logic [15:0] h;
        w  = it.data_in;
        st = ST_OK;
        if (fmt == FMT_IEEE)
        begin
            r.data_out = w;
            st = ((w & F_EXP_MASK) == F_EXP_MASK && (w & F_MAN_MASK) != 0) ? ST_NAN : ST_OK;
        end
        else if (!it.cmd)
        begin
            case (fmt)
                FMT_IBM:
                begin
                    r.data_out = ibm_decode(w, st);
                end
                FMT_INT32:
                begin
                    mag = w[31] ? {32'd0, 32'd0 - w} : {32'd0, w};
                    r.data_out = int_decode({w[31], 31'd0}, mag, st);
                end
                default:
                begin
                    h   = w[15:0];
                    mag = h[15] ? 64'h10000 - {48'd0, h} : {48'd0, h};
                    r.data_out = int_decode({h[15], 31'd0}, mag, st);
                end
            endcase
        end
        else
        begin
            case (fmt)
                FMT_IBM:   r.data_out = ibm_encode(w, st);
                FMT_INT32: r.data_out = int_encode(w, 32, st);
                default:   r.data_out = int_encode(w, 16, st);
            endcase
        end
        r.status   = st;
        r.last_out = it.last_in;
        return r;
    endfunction

    assign pending = converted_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cur_fmt    <= FMT_IBM;
            mismatches <= 0;
            converted_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SAMPLE_FORMAT)
            begin
                cur_fmt <= fmt_t'(pwdata[1:0]);
            end
            if (in_valid && in_ready)
            begin
                converted_q.push_back(convert_sample(cur_fmt, in_data));
            end
            if (out_valid && out_ready)
            begin
                if (converted_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("ERROR: unexpected result beat %h", out_data);
                    end
                end
                else
                begin
                    want = converted_q.pop_front();
                    if (want.data_out !== out_data.data_out || want.status !== out_data.status
                        || want.last_out !== out_data.last_out)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("ERROR: data/status/last exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.data_out, want.status, want.last_out,
                                     out_data.data_out, out_data.status, out_data.last_out);
                        end
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_seismic_sample_format_converter.sv */
// Testbench top for the seismic sample format converter: stimulus, clock and verdict.
module tb_seismic_sample_format_converter;
    timeunit 1ns;
    timeprecision 1ps;
    import ssfc_pkg::*;

    localparam int         CYCLE_LIMIT        = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_taken;
    logic        no_idle;
    int          mismatches;
    int          pending;
    int          cycles = 0;

    seismic_sample_format_converter DUT (.*);

    ssfc_checker u_checker (
        .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .mismatches, .pending
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        cycles   <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    task automatic write_format(input fmt_t fmt);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SAMPLE_FORMAT;
        pwdata  <= {30'd0, fmt};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold in_valid low and drain every expected beat, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Valid stays high between back-to-back beats and drops only while idling.
    task automatic send_sample(input logic cmd, input logic [31:0] w);
        while (!no_idle && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: cmd, data_in: w, last_in: 1'($urandom)};
        do
        begin
            @(negedge clk);
        end
        while (!in_taken);
    endtask

    function automatic logic [31:0] pick_word();
        logic s;
        s = 1'($urandom);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {s, 7'($urandom), 24'($urandom) >> $urandom_range(0, 23)};
            2: return {s, 8'($urandom_range(100, 165)), 23'($urandom)};
            3: return {s, ($urandom_range(0, 1) ? 8'hff : 8'h00),
                       ($urandom_range(0, 2) == 0 ? 23'd0
                                                  : 23'($urandom) >> $urandom_range(0, 22))};
            4: return 32'($urandom_range(0, 140000)) - 32'd70000 + (s ? 32'h8000 : 32'h0);
            default: return (s ? 32'h80000000 : 32'h7fffffff) + 32'($urandom_range(0, 8)) - 32'd4;
        endcase
    endfunction

    logic [31:0] corner_words[12] = '{
        32'h00000000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000001, 32'h7f800000,
        32'hff800000, 32'h7fc00000, 32'h00800000, 32'h4f000000, 32'h00000010, 32'h0000ffff
    };
    fmt_t phase_fmt[6] = '{FMT_IBM, FMT_INT32, FMT_INT16, FMT_IEEE, FMT_INT32, FMT_IBM};

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_format(phase_fmt[ph]);
            if (ph < 4)
            begin
                foreach (corner_words[i])
                begin
                    send_sample(1'b0, corner_words[i]);
                    send_sample(1'b1, corner_words[i]);
                end
            end
            // The random part of the second phase runs with no idling on either side.
            no_idle = (ph == 1);
            for (int n = 0; n < 180; n++)
            begin
                if (n == 90)
                begin
                    in_valid <= 1'b0;
                    do
                    begin
                        @(negedge clk);
                    end
                    while (pending != 0);
                end
                send_sample(1'($urandom), pick_word());
            end
            no_idle = 1'b0;
            drain();
        end
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
